// File: design/knn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// knn_pkg
// Shared types, codes and sizes of the nearest neighbor selector.
// ----------------------------------------------------------------------------
package knn_pkg;

  localparam int MAX_POINTS_DEF    = 1024;
  localparam int MAX_NEIGHBORS_DEF = 8;

  localparam int COORD_W = 16;
  localparam int INDEX_W = 10;
  localparam int DIST_W  = 33;
  localparam int RANK_W  = 3;
  localparam int CMD_W   = 2;
  localparam int KCFG_W  = 4;
  localparam int SQ_W    = 2 * COORD_W;

  localparam logic [KCFG_W-1:0] NEIGHBOR_COUNT_RST = 4'd3;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_CLEAR  = 2'd1;
  localparam logic [1:0] CELL_INSERT = 2'd2;
  localparam logic [1:0] CELL_SHIFT  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [INDEX_W-1:0] source_index;
  } knn_req_t;

  typedef struct packed {
    logic [INDEX_W-1:0] origin_index;
    logic [INDEX_W-1:0] neighbor_index;
    logic [DIST_W-1:0]  squared_distance;
    logic [RANK_W-1:0]  rank;
    logic               last;
  } knn_res_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [DIST_W-1:0] distance;
  } knn_cell_ctl_t;

endpackage
`default_nettype wire

// File: design/knn_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// knn_cell
// One slot of the sorted best list: inserts, shifts right on insert and
// shifts left while the list is read out.
// ----------------------------------------------------------------------------
module knn_cell
  import knn_pkg::*;
#(
  parameter int IDX_W = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire knn_cell_ctl_t     ctl,
  input  wire logic [IDX_W-1:0]  cand_idx,
  input  wire logic              enable,
  input  wire logic              left_ins,
  input  wire logic              left_valid,
  input  wire logic [DIST_W-1:0] left_dist,
  input  wire logic [IDX_W-1:0]  left_idx,
  input  wire logic              right_valid,
  input  wire logic [DIST_W-1:0] right_dist,
  input  wire logic [IDX_W-1:0]  right_idx,
  output logic                   valid,
  output logic [DIST_W-1:0]      distance,
  output logic [IDX_W-1:0]       idx,
  output logic                   ins
);

  // strict compare keeps the earlier (lower) index ahead on ties
  assign ins = enable && (ctl.op == CELL_INSERT) && (!valid || (ctl.distance < distance));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (ctl.op)
        CELL_CLEAR: begin
          valid <= 1'b0;
        end
        CELL_INSERT: begin
          if (ins) begin
            if (left_ins) begin
              valid    <= left_valid;
              distance <= left_dist;
              idx      <= left_idx;
            end else begin
              valid    <= 1'b1;
              distance <= ctl.distance;
              idx      <= cand_idx;
            end
          end
        end
        CELL_SHIFT: begin
          valid    <= right_valid;
          distance <= right_dist;
          idx      <= right_idx;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/k_nearest_neighbor_select.sv
`default_nettype none
// ----------------------------------------------------------------------------
// k_nearest_neighbor_select
// Load and clear never raise busy. A query whose source index is below the store
// count holds busy high through the source read, the scan of one stored point per
// cycle, the four-stage distance flush and the drain of the best list; results
// come out one per cycle with no stall. Synchronous reset empties the store
// count, the best list and sets neighbor_count to 3.
// ----------------------------------------------------------------------------
module k_nearest_neighbor_select
  import knn_pkg::*;
#(
  parameter int MAX_POINTS    = MAX_POINTS_DEF,
  parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire knn_req_t          request,
  output logic                   busy,
  output logic                   result_valid,
  output knn_res_t               result,
  input  wire logic              cfg_we,
  input  wire logic [KCFG_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam int KW    = 6;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SRC   = 3'd1;
  localparam logic [2:0] ST_SRCW  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;

  logic [2:0]          state;
  logic [KCFG_W-1:0]   neighbor_count;
  logic [CNT_W-1:0]    points_loaded;
  logic [INDEX_W-1:0]  src;
  logic [IDX_W-1:0]    scan_j;
  logic [COORD_W-1:0]  sx, sy;
  logic [RANK_W-1:0]   rank;
  logic [KW-1:0]       k_clamp;

  logic [2*COORD_W-1:0] mem [MAX_POINTS];
  logic [2*COORD_W-1:0] rd_data;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;

  logic              s1_valid, s2_valid, s3_valid, s4_valid;
  logic [IDX_W-1:0]  s1_idx, s2_idx, s3_idx, s4_idx;
  logic [COORD_W-1:0] s2_dx, s2_dy;
  logic [SQ_W-1:0]   s3_sqx, s3_sqy;
  logic [DIST_W-1:0] s4_dist;

  knn_cell_ctl_t     cell_ctl;
  logic              c_valid [MAX_NEIGHBORS];
  logic [DIST_W-1:0] c_dist  [MAX_NEIGHBORS];
  logic [IDX_W-1:0]  c_idx   [MAX_NEIGHBORS];
  logic              c_ins   [MAX_NEIGHBORS];
  logic              out_last;
  logic              accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    k_clamp = KW'(neighbor_count);
    if (k_clamp == '0) begin
      k_clamp = KW'(1);
    end else if (k_clamp > KW'(MAX_NEIGHBORS)) begin
      k_clamp = KW'(MAX_NEIGHBORS);
    end
  end

  // point store
  assign wr_en = accept && (request.command == CMD_LOAD) &&
                 (points_loaded != CNT_W'(MAX_POINTS));
  assign rd_en = (state == ST_SRC) || (state == ST_SCAN);
  assign rd_addr = (state == ST_SRC) ? IDX_W'(src) : scan_j;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IDX_W'(points_loaded)] <= {request.pos_x, request.pos_y};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbor_count <= NEIGHBOR_COUNT_RST;
    end else if (cfg_we) begin
      neighbor_count <= cfg_data;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      points_loaded <= '0;
      rank          <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (request.command)
              CMD_LOAD: begin
                if (wr_en) begin
                  points_loaded <= points_loaded + CNT_W'(1);
                end
              end
              CMD_CLEAR: begin
                points_loaded <= '0;
              end
              CMD_QUERY: begin
                src <= request.source_index;
                if (CMP_W'(request.source_index) < CMP_W'(points_loaded)) begin
                  state <= ST_SRC;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SRC: begin
          state <= ST_SRCW;
        end
        ST_SRCW: begin
          sx     <= rd_data[2*COORD_W-1:COORD_W];
          sy     <= rd_data[COORD_W-1:0];
          scan_j <= '0;
          state  <= ST_SCAN;
        end
        ST_SCAN: begin
          scan_j <= scan_j + IDX_W'(1);
          if (CNT_W'(scan_j) == points_loaded - CNT_W'(1)) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          rank <= '0;
          if (!(s1_valid || s2_valid || s3_valid || s4_valid)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          rank <= rank + RANK_W'(1);
          if (!c_valid[0] || out_last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // distance pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= (state == ST_SCAN) && (CMP_W'(scan_j) != CMP_W'(src));
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx  <= scan_j;
    s2_idx  <= s1_idx;
    s2_dx   <= (sx > rd_data[2*COORD_W-1:COORD_W]) ? sx - rd_data[2*COORD_W-1:COORD_W]
                                                   : rd_data[2*COORD_W-1:COORD_W] - sx;
    s2_dy   <= (sy > rd_data[COORD_W-1:0]) ? sy - rd_data[COORD_W-1:0]
                                           : rd_data[COORD_W-1:0] - sy;
    s3_idx  <= s2_idx;
    s3_sqx  <= s2_dx * s2_dx;
    s3_sqy  <= s2_dy * s2_dy;
    s4_idx  <= s3_idx;
    s4_dist <= DIST_W'(s3_sqx) + DIST_W'(s3_sqy);
  end

  // best-list cell chain
  always_comb begin
    cell_ctl.distance = s4_dist;
    cell_ctl.op       = CELL_HOLD;
    if (accept && (request.command == CMD_QUERY)) begin
      cell_ctl.op = CELL_CLEAR;
    end else if (s4_valid) begin
      cell_ctl.op = CELL_INSERT;
    end else if (state == ST_DRAIN) begin
      cell_ctl.op = CELL_SHIFT;
    end
  end

  for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
    logic              l_ins, l_valid, r_valid;
    logic [DIST_W-1:0] l_dist, r_dist;
    logic [IDX_W-1:0]  l_idx, r_idx;

    if (i == 0) begin : g_head
      assign l_ins   = 1'b0;
      assign l_valid = 1'b0;
      assign l_dist  = '0;
      assign l_idx   = '0;
    end else begin : g_body
      assign l_ins   = c_ins[i-1];
      assign l_valid = c_valid[i-1];
      assign l_dist  = c_dist[i-1];
      assign l_idx   = c_idx[i-1];
    end

    if (i == MAX_NEIGHBORS - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_dist  = '0;
      assign r_idx   = '0;
    end else begin : g_next
      assign r_valid = c_valid[i+1];
      assign r_dist  = c_dist[i+1];
      assign r_idx   = c_idx[i+1];
    end

    knn_cell #(
      .IDX_W(IDX_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (cell_ctl),
      .cand_idx   (s4_idx),
      .enable     (KW'(i) < k_clamp),
      .left_ins   (l_ins),
      .left_valid (l_valid),
      .left_dist  (l_dist),
      .left_idx   (l_idx),
      .right_valid(r_valid),
      .right_dist (r_dist),
      .right_idx  (r_idx),
      .valid      (c_valid[i]),
      .distance   (c_dist[i]),
      .idx        (c_idx[i]),
      .ins        (c_ins[i])
    );
  end

  if (MAX_NEIGHBORS > 1) begin : g_last_multi
    assign out_last = !c_valid[1];
  end else begin : g_last_single
    assign out_last = 1'b1;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == ST_DRAIN) && c_valid[0];
    end
  end

  always_ff @(posedge clk) begin
    result.origin_index     <= src;
    result.neighbor_index   <= INDEX_W'(c_idx[0]);
    result.squared_distance <= c_dist[0];
    result.rank             <= rank;
    result.last             <= out_last;
  end

endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest neighbor selector. Directed and random
// load, query and clear transactions drive the block, a behavioral predictor
// computes the neighbor list of every query, and each result is compared
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb;
  import knn_pkg::*;

  localparam int MAX_PTS     = MAX_POINTS_DEF;
  localparam int MAX_NB      = MAX_NEIGHBORS_DEF;
  localparam int SETTLE      = MAX_POINTS_DEF + 4 * MAX_NEIGHBORS_DEF + 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 410;
  localparam int REQ_W       = $bits(knn_req_t);
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  knn_req_t          request = '0;
  logic              busy;
  logic              result_valid;
  knn_res_t          result;
  logic              cfg_we = 1'b0;
  logic [KCFG_W-1:0] cfg_data = '0;

  logic [2*COORD_W-1:0] point_xy [MAX_PTS];
  int                   point_total = 0;
  int                   k_setting = int'(NEIGHBOR_COUNT_RST);
  knn_res_t             pending_neighbors [$];
  int                   mismatch_count = 0;
  int                   cycle_count = 0;
  bit                   back_to_back = 1'b0;

  k_nearest_neighbor_select uut (
    .clk,
    .rst,
    .start,
    .request,
    .busy,
    .result_valid,
    .result,
    .cfg_we,
    .cfg_data
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    knn_res_t want;
    if (!rst && result_valid) begin
      if (pending_neighbors.size() == 0) begin
        report_mismatch($sformatf("unexpected result origin %0d neighbor %0d rank %0d",
                                  result.origin_index, result.neighbor_index, result.rank));
      end else begin
        want = pending_neighbors.pop_front();
        if (result.origin_index !== want.origin_index)
          report_mismatch($sformatf("origin_index got %0d want %0d",
                                    result.origin_index, want.origin_index));
        if (result.neighbor_index !== want.neighbor_index)
          report_mismatch($sformatf("neighbor_index got %0d want %0d (origin %0d rank %0d)",
                                    result.neighbor_index, want.neighbor_index,
                                    want.origin_index, want.rank));
        if (result.squared_distance !== want.squared_distance)
          report_mismatch($sformatf("squared_distance got %0d want %0d (origin %0d rank %0d)",
                                    result.squared_distance, want.squared_distance,
                                    want.origin_index, want.rank));
        if (result.rank !== want.rank)
          report_mismatch($sformatf("rank got %0d want %0d", result.rank, want.rank));
        if (result.last !== want.last)
          report_mismatch($sformatf("last got %0d want %0d (origin %0d rank %0d)",
                                    result.last, want.last, want.origin_index, want.rank));
      end
    end
  end

  function automatic void compute_neighbors(input knn_req_t req);
    logic [DIST_W-1:0]  best_dist [MAX_NB];
    logic [INDEX_W-1:0] best_idx [MAX_NB];
    logic [COORD_W-1:0] sx, sy, px, py, dx, dy;
    logic [DIST_W-1:0]  distance;
    knn_res_t           res;
    int                 found, k, pos, src;
    case (req.command)
      CMD_LOAD: begin
        if (point_total < MAX_PTS) begin
          point_xy[point_total] = {req.pos_x, req.pos_y};
          point_total++;
        end
      end
      CMD_CLEAR: point_total = 0;
      CMD_QUERY: begin
        src = req.source_index;
        if (src < point_total) begin
          k = (k_setting == 0) ? 1 : ((k_setting > MAX_NB) ? MAX_NB : k_setting);
          found = 0;
          {sx, sy} = point_xy[src];
          for (int j = 0; j < point_total; j++) begin
            if (j != src) begin
              {px, py} = point_xy[j];
              dx = (sx > px) ? sx - px : px - sx;
              dy = (sy > py) ? sy - py : py - sy;
              distance = DIST_W'(dx) * DIST_W'(dx) + DIST_W'(dy) * DIST_W'(dy);
              pos = found;
              while (pos > 0 && distance < best_dist[pos-1]) pos--;
              if (pos < k) begin
                for (int m = (found < k) ? found : k - 1; m > pos; m--) begin
                  best_dist[m] = best_dist[m-1];
                  best_idx[m]  = best_idx[m-1];
                end
                best_dist[pos] = distance;
                best_idx[pos]  = INDEX_W'(j);
                if (found < k) found++;
              end
            end
          end
          for (int n = 0; n < found; n++) begin
            res.origin_index     = INDEX_W'(src);
            res.neighbor_index   = best_idx[n];
            res.squared_distance = best_dist[n];
            res.rank             = RANK_W'(n);
            res.last             = (n == found - 1);
            pending_neighbors    = {pending_neighbors, res};
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(input knn_req_t req);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    compute_neighbors(req);
  endtask

  task automatic load_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    knn_req_t req;
    req.command      = CMD_LOAD;
    req.pos_x        = x;
    req.pos_y        = y;
    req.source_index = INDEX_W'($urandom);
    send_request(req);
  endtask

  task automatic query_point(input logic [INDEX_W-1:0] src);
    knn_req_t req;
    req.command      = CMD_QUERY;
    req.pos_x        = COORD_W'($urandom);
    req.pos_y        = COORD_W'($urandom);
    req.source_index = src;
    send_request(req);
  endtask

  task automatic clear_store();
    knn_req_t req;
    req              = knn_req_t'(REQ_W'({$urandom, $urandom}));
    req.command      = CMD_CLEAR;
    send_request(req);
  endtask

  task automatic send_noise();
    knn_req_t req;
    req         = knn_req_t'(REQ_W'({$urandom, $urandom}));
    req.command = CMD_UNUSED;
    send_request(req);
  endtask

  // Hold off until every predicted result is in and the block is done.
  task automatic quiesce();
    start <= 1'b0;
    while (pending_neighbors.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_neighbor_count(input int value);
    quiesce();
    cfg_we   <= 1'b1;
    cfg_data <= KCFG_W'(value);
    @(posedge clk);
    cfg_we   <= 1'b0;
    k_setting = value;
  endtask

  function automatic logic [COORD_W-1:0] draw_coord(input int mode);
    case (mode)
      0:       return COORD_W'($urandom);
      1:       return COORD_W'($urandom_range(0, 7) * 16);
      2:       return $urandom_range(0, 1) ? '1 : '0;
      default: return COORD_W'(30000 + $urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_reset_defaults();
    load_point('0, '0);
    load_point('1, '1);
    load_point('0, '1);
    load_point('1, '0);
    load_point(16'd16, 16'd16);
    query_point(10'd0);
    query_point(10'd1);
    query_point(10'd4);
    query_point(10'd5);
    query_point('1);
    send_noise();
  endtask

  task automatic test_ties_and_small_sets();
    set_neighbor_count(MAX_NB);
    clear_store();
    load_point(16'd100, 16'd100);
    load_point(16'd110, 16'd100);
    load_point(16'd90, 16'd100);
    load_point(16'd100, 16'd110);
    load_point(16'd100, 16'd90);
    load_point(16'd100, 16'd100);
    load_point(16'd116, 16'd116);
    query_point(10'd0);
    query_point(10'd5);
    set_neighbor_count(0);
    clear_store();
    load_point(16'd500, 16'd7);
    query_point(10'd0);
    load_point(16'd9, 16'd800);
    query_point(10'd1);
  endtask

  task automatic test_random_traffic();
    int sent, n_load, n_query, mode, src;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       set_neighbor_count(0);
        1:       set_neighbor_count(1);
        2:       set_neighbor_count(MAX_NB);
        3:       set_neighbor_count(15);
        default: set_neighbor_count($urandom_range(0, 15));
      endcase
      back_to_back = ($urandom_range(0, 4) == 0);
      if (point_total > 48 || $urandom_range(0, 3) != 0) begin
        clear_store();
        sent++;
      end
      mode = $urandom_range(0, 3);
      n_load = $urandom_range(1, 20);
      repeat (n_load) begin
        load_point(draw_coord(mode), draw_coord(mode));
        sent++;
      end
      n_query = $urandom_range(1, 10);
      repeat (n_query) begin
        case ($urandom_range(0, 9))
          0: send_noise();
          1: begin
            src = $urandom_range(0, 1023);
            query_point(INDEX_W'(src));
            if (src < point_total) sent++;
          end
          2: begin
            load_point(draw_coord(mode), draw_coord(mode));
            sent++;
          end
          default: begin
            query_point(INDEX_W'($urandom_range(0, point_total - 1)));
            sent++;
          end
        endcase
      end
    end
    back_to_back = 1'b0;
  endtask

  task automatic test_full_store();
    set_neighbor_count(15);
    clear_store();
    repeat (MAX_PTS) load_point(draw_coord(0), draw_coord(0));
    // drop: store is full, count stays
    load_point('0, '0);
    query_point(10'd1023);
    query_point(10'd0);
    query_point(10'd700);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_ties_and_small_sets();
    test_random_traffic();
    test_full_store();
    quiesce();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
